### sv/rfa_pkg.sv
// rfa_pkg: shared types and constants for the register file alu
// holds the command encoding, state enums and the alu control structs
// no dependencies
`default_nettype none

package rfa_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);

    typedef enum logic [3:0] {
        CMD_MOV  = 4'd0,
        CMD_XCHG = 4'd1,
        CMD_INC  = 4'd2,
        CMD_DEC  = 4'd3,
        CMD_ADD  = 4'd4,
        CMD_SUB  = 4'd5,
        CMD_NEG  = 4'd6,
        CMD_NOT  = 4'd7,
        CMD_AND  = 4'd8,
        CMD_OR   = 4'd9,
        CMD_XOR  = 4'd10,
        CMD_MUL  = 4'd11,
        CMD_DIV  = 4'd12,
        CMD_REM  = 4'd13,
        CMD_MAX  = 4'd14,
        CMD_MIN  = 4'd15
    } cmd_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_READ,
        T_EXEC,
        T_WAIT,
        T_SWAP
    } top_state_t;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_PREP,
        ALU_RUN,
        ALU_FIX,
        ALU_DONE
    } alu_state_t;

    typedef struct packed {
        logic start;
        cmd_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

endpackage

`default_nettype wire

### sv/rfa_alu.sv
// rfa_alu: serial alu, one bit per cycle over a 32-step run
// bit-serial add/sub/logic, shift-add multiply, restoring divide
// depends on rfa_pkg
`default_nettype none

module rfa_alu (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rfa_pkg::alu_req_t          req,
    input  wire logic [rfa_pkg::WORD_W-1:0] a,
    input  wire logic [rfa_pkg::WORD_W-1:0] b,
    output rfa_pkg::alu_rsp_t               rsp,
    output logic [rfa_pkg::WORD_W-1:0]      result
);

    localparam int W  = rfa_pkg::WORD_W;
    localparam int CW = rfa_pkg::CNT_W;

    rfa_pkg::alu_state_t state_reg, state_next;
    rfa_pkg::cmd_t       op_reg, op_next;

    logic [W-1:0]  a_keep_reg, a_keep_next;
    logic [W-1:0]  b_keep_reg, b_keep_next;
    logic [W-1:0]  sa_reg, sa_next;
    logic [W-1:0]  sb_reg, sb_next;
    logic [W-1:0]  sr_reg, sr_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  res_reg, res_next;
    logic          carry_reg, carry_next;
    logic          dz_reg, dz_next;
    logic          neg_q_reg, neg_q_next;
    logic          neg_r_reg, neg_r_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic last_step;
    logic b_zero;

    assign last_step = (cnt_reg == CW'(W - 1));
    assign b_zero    = (b_keep_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfa_pkg::ALU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_keep_reg <= a_keep_next;
        b_keep_reg <= b_keep_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        sr_reg     <= sr_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        carry_reg  <= carry_next;
        dz_reg     <= dz_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        cnt_reg    <= cnt_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rfa_pkg::ALU_IDLE:
            begin
                if (req.start)
                begin
                    state_next = rfa_pkg::ALU_PREP;
                end
            end
            rfa_pkg::ALU_PREP:
            begin
                if ((op_reg == rfa_pkg::CMD_DIV || op_reg == rfa_pkg::CMD_REM) && b_zero)
                begin
                    state_next = rfa_pkg::ALU_DONE;
                end
                else
                begin
                    state_next = rfa_pkg::ALU_RUN;
                end
            end
            rfa_pkg::ALU_RUN:
            begin
                if (last_step)
                begin
                    state_next = rfa_pkg::ALU_FIX;
                end
            end
            rfa_pkg::ALU_FIX:
            begin
                state_next = rfa_pkg::ALU_DONE;
            end
            rfa_pkg::ALU_DONE:
            begin
                state_next = rfa_pkg::ALU_IDLE;
            end
            default:
            begin
                state_next = rfa_pkg::ALU_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        logic         sbit;
        logic         cout;
        logic         rbit;
        logic         qbit;
        logic         lt;
        logic [W:0]   mul_sum;
        logic [W:0]   trial;

        op_next     = op_reg;
        a_keep_next = a_keep_reg;
        b_keep_next = b_keep_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        sr_next     = sr_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        carry_next  = carry_reg;
        dz_next     = dz_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        cnt_next    = cnt_reg;

        sbit    = sa_reg[0] ^ sb_reg[0] ^ carry_reg;
        cout    = (sa_reg[0] & sb_reg[0]) | (carry_reg & (sa_reg[0] ^ sb_reg[0]));
        rbit    = sbit;
        qbit    = 1'b0;
        mul_sum = {1'b0, acc_reg} + (sb_reg[0] ? {1'b0, a_keep_reg} : '0);
        trial   = {acc_reg, sa_reg[W-1]} - {1'b0, sb_reg};
        // signed a < b from the serial a - b carry
        lt      = (a_keep_reg[W-1] != b_keep_reg[W-1]) ? a_keep_reg[W-1] : !carry_reg;

        unique case (state_reg)
            rfa_pkg::ALU_IDLE:
            begin
                if (req.start)
                begin
                    op_next     = req.op;
                    a_keep_next = a;
                    b_keep_next = b;
                end
            end
            rfa_pkg::ALU_PREP:
            begin
                cnt_next   = '0;
                carry_next = 1'b0;
                acc_next   = '0;
                sr_next    = '0;
                dz_next    = 1'b0;
                sa_next    = a_keep_reg;
                sb_next    = b_keep_reg;
                unique case (op_reg) inside
                    rfa_pkg::CMD_MOV:
                    begin
                        sa_next = b_keep_reg;
                        sb_next = '0;
                    end
                    rfa_pkg::CMD_INC:
                    begin
                        sb_next = W'(1);
                    end
                    rfa_pkg::CMD_DEC:
                    begin
                        sb_next    = ~W'(1);
                        carry_next = 1'b1;
                    end
                    rfa_pkg::CMD_SUB, rfa_pkg::CMD_MAX, rfa_pkg::CMD_MIN:
                    begin
                        sb_next    = ~b_keep_reg;
                        carry_next = 1'b1;
                    end
                    rfa_pkg::CMD_NEG:
                    begin
                        sa_next    = '0;
                        sb_next    = ~a_keep_reg;
                        carry_next = 1'b1;
                    end
                    rfa_pkg::CMD_NOT:
                    begin
                        sb_next = '1;
                    end
                    rfa_pkg::CMD_DIV, rfa_pkg::CMD_REM:
                    begin
                        sa_next    = a_keep_reg[W-1] ? (W'(0) - a_keep_reg) : a_keep_reg;
                        sb_next    = b_keep_reg[W-1] ? (W'(0) - b_keep_reg) : b_keep_reg;
                        neg_q_next = a_keep_reg[W-1] ^ b_keep_reg[W-1];
                        neg_r_next = a_keep_reg[W-1];
                        if (b_zero)
                        begin
                            dz_next  = 1'b1;
                            res_next = a_keep_reg;
                        end
                    end
                    default:
                    begin
                        sa_next = a_keep_reg;
                    end
                endcase
            end
            rfa_pkg::ALU_RUN:
            begin
                cnt_next = cnt_reg + CW'(1);
                unique case (op_reg) inside
                    rfa_pkg::CMD_MUL:
                    begin
                        // shift-add, product bits leave the accumulator lsb first
                        sr_next  = {mul_sum[0], sr_reg[W-1:1]};
                        acc_next = mul_sum[W:1];
                        sb_next  = {1'b0, sb_reg[W-1:1]};
                    end
                    rfa_pkg::CMD_DIV, rfa_pkg::CMD_REM:
                    begin
                        // restoring step, quotient bits fill sa from the right
                        if (!trial[W])
                        begin
                            acc_next = trial[W-1:0];
                            qbit     = 1'b1;
                        end
                        else
                        begin
                            acc_next = {acc_reg[W-2:0], sa_reg[W-1]};
                        end
                        sa_next = {sa_reg[W-2:0], qbit};
                    end
                    default:
                    begin
                        unique case (op_reg) inside
                            rfa_pkg::CMD_AND:
                            begin
                                rbit = sa_reg[0] & sb_reg[0];
                            end
                            rfa_pkg::CMD_OR:
                            begin
                                rbit = sa_reg[0] | sb_reg[0];
                            end
                            rfa_pkg::CMD_XOR, rfa_pkg::CMD_NOT:
                            begin
                                rbit = sa_reg[0] ^ sb_reg[0];
                            end
                            default:
                            begin
                                rbit       = sbit;
                                carry_next = cout;
                            end
                        endcase
                        sr_next = {rbit, sr_reg[W-1:1]};
                        sa_next = {1'b0, sa_reg[W-1:1]};
                        sb_next = {1'b0, sb_reg[W-1:1]};
                    end
                endcase
            end
            rfa_pkg::ALU_FIX:
            begin
                unique case (op_reg) inside
                    rfa_pkg::CMD_MAX:
                    begin
                        res_next = lt ? b_keep_reg : a_keep_reg;
                    end
                    rfa_pkg::CMD_MIN:
                    begin
                        res_next = lt ? a_keep_reg : b_keep_reg;
                    end
                    rfa_pkg::CMD_DIV:
                    begin
                        res_next = neg_q_reg ? (W'(0) - sa_reg) : sa_reg;
                    end
                    rfa_pkg::CMD_REM:
                    begin
                        res_next = neg_r_reg ? (W'(0) - acc_reg) : acc_reg;
                    end
                    default:
                    begin
                        res_next = sr_reg;
                    end
                endcase
            end
            rfa_pkg::ALU_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        rsp.done     = (state_reg == rfa_pkg::ALU_DONE);
        rsp.div_zero = dz_reg;
        result       = res_reg;
    end

endmodule

`default_nettype wire

### sv/register_file_alu_top.sv
// register_file_alu_top: register file with a serial two-operand alu
// holds the register memory, its valid bits and the command sequencer
// depends on rfa_pkg and rfa_alu
`default_nettype none

// One command is taken when start is high and busy is low; busy then stays
// high until the result word has been produced. The result appears on
// dest_value, other_value and div_by_zero for exactly one cycle with done
// high, and a new command may be started in that same cycle. Every command
// first reads both registers. An exchange then writes the source and then
// the destination; divide or remainder by zero skips the run; else the alu runs
// 32 single-bit steps (bit-serial add and logic, shift-add multiply,
// restoring divide) framed by a setup and a sign-fix step, then the
// write-back. The register file reads as all zeros after reset through
// per-register valid bits, so no clearing pass is needed.
module register_file_alu_top #(
    parameter int REG_COUNT = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [3:0]         cmd,
    input  wire logic [4:0]         dest_index,
    input  wire logic signed [31:0] src_operand,
    input  wire logic               is_imm,
    output logic                    done,
    output logic signed [31:0]      dest_value,
    output logic signed [31:0]      other_value,
    output logic                    div_by_zero
);

    localparam int W     = rfa_pkg::WORD_W;
    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    // 8-bit carrier reduced modulo REG_COUNT by eight compare-subtract steps
    function automatic logic [IDX_W-1:0] reg_index(input logic [7:0] carrier);
        logic [15:0] v;
        logic [15:0] m;
        v = {8'd0, carrier};
        for (int k = 7; k >= 0; k--)
        begin
            m = 16'(REG_COUNT) << k;
            if (v >= m)
            begin
                v = v - m;
            end
        end
        return v[IDX_W-1:0];
    endfunction

    rfa_pkg::top_state_t state_reg, state_next;
    rfa_pkg::cmd_t       cmd_reg;
    rfa_pkg::alu_req_t   alu_req;
    rfa_pkg::alu_rsp_t   alu_rsp;

    logic [IDX_W-1:0]     d_idx_reg;
    logic [IDX_W-1:0]     s_idx_reg;
    logic                 imm_reg;
    logic [W-1:0]         src_reg;

    logic [W-1:0]         mem_array [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [W-1:0]         rd_d_reg;
    logic [W-1:0]         rd_s_reg;
    logic                 vld_d_reg;
    logic                 vld_s_reg;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [W-1:0]         mem_wdata;
    logic                 rd_en;

    logic [W-1:0]         a_val;
    logic [W-1:0]         s_val;
    logic [W-1:0]         b_val;
    logic [W-1:0]         alu_result;

    logic                 done_reg, done_next;
    logic [W-1:0]         dest_value_reg, dest_value_next;
    logic [W-1:0]         other_value_reg, other_value_next;
    logic                 dz_out_reg, dz_out_next;

    logic                 accept;

    assign accept = start && !busy;
    assign a_val  = vld_d_reg ? rd_d_reg : '0;
    assign s_val  = vld_s_reg ? rd_s_reg : '0;
    assign b_val  = imm_reg ? src_reg : s_val;

    rfa_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (a_val),
        .b      (b_val),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfa_pkg::T_IDLE;
            done_reg  <= 1'b0;
            vld_reg   <= '0;
            vld_d_reg <= 1'b0;
            vld_s_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_d_reg <= vld_reg[d_idx_reg];
                vld_s_reg <= vld_reg[s_idx_reg];
            end
        end
    end

    // register memory, one write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_d_reg <= mem_array[d_idx_reg];
            rd_s_reg <= mem_array[s_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= rfa_pkg::cmd_t'(cmd);
            d_idx_reg <= reg_index({3'b000, dest_index});
            s_idx_reg <= reg_index(src_operand[7:0]);
            imm_reg   <= is_imm;
            src_reg   <= src_operand;
        end
        dest_value_reg  <= dest_value_next;
        other_value_reg <= other_value_next;
        dz_out_reg      <= dz_out_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rfa_pkg::T_IDLE:
            begin
                if (start)
                begin
                    state_next = rfa_pkg::T_READ;
                end
            end
            rfa_pkg::T_READ:
            begin
                state_next = rfa_pkg::T_EXEC;
            end
            rfa_pkg::T_EXEC:
            begin
                if (cmd_reg == rfa_pkg::CMD_XCHG)
                begin
                    state_next = rfa_pkg::T_SWAP;
                end
                else
                begin
                    state_next = rfa_pkg::T_WAIT;
                end
            end
            rfa_pkg::T_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    state_next = rfa_pkg::T_IDLE;
                end
            end
            rfa_pkg::T_SWAP:
            begin
                state_next = rfa_pkg::T_IDLE;
            end
            default:
            begin
                state_next = rfa_pkg::T_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy             = (state_reg != rfa_pkg::T_IDLE);
        rd_en            = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = d_idx_reg;
        mem_wdata        = alu_result;
        alu_req.start    = 1'b0;
        alu_req.op       = cmd_reg;
        done_next        = 1'b0;
        dest_value_next  = dest_value_reg;
        other_value_next = other_value_reg;
        dz_out_next      = dz_out_reg;
        unique case (state_reg)
            rfa_pkg::T_IDLE:
            begin
                rd_en = 1'b0;
            end
            rfa_pkg::T_READ:
            begin
                rd_en = 1'b1;
            end
            rfa_pkg::T_EXEC:
            begin
                if (cmd_reg == rfa_pkg::CMD_XCHG)
                begin
                    // source first, so equal indexes end with the old value
                    mem_we    = 1'b1;
                    mem_waddr = s_idx_reg;
                    mem_wdata = a_val;
                end
                else
                begin
                    alu_req.start = 1'b1;
                end
            end
            rfa_pkg::T_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    mem_we           = 1'b1;
                    mem_wdata        = alu_result;
                    done_next        = 1'b1;
                    dest_value_next  = alu_result;
                    other_value_next = '0;
                    dz_out_next      = alu_rsp.div_zero;
                end
            end
            rfa_pkg::T_SWAP:
            begin
                mem_we           = 1'b1;
                mem_wdata        = s_val;
                done_next        = 1'b1;
                dest_value_next  = s_val;
                other_value_next = a_val;
                dz_out_next      = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign done        = done_reg;
    assign dest_value  = dest_value_reg;
    assign other_value = other_value_reg;
    assign div_by_zero = dz_out_reg;

    // a result word only follows a write-back
    a_done_after_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == rfa_pkg::T_WAIT || $past(state_reg) == rfa_pkg::T_SWAP))
        else $error("result word without write-back");

    // alu completion is only seen while the sequencer waits for it
    a_alu_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> state_reg == rfa_pkg::T_WAIT)
        else $error("alu finished outside of wait");

    // zero-divisor flag only for divide and remainder
    a_dz_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_by_zero) |-> (cmd_reg == rfa_pkg::CMD_DIV || cmd_reg == rfa_pkg::CMD_REM))
        else $error("div_by_zero on a non-divide command");

    // other_value is zero except after an exchange
    a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && other_value != '0) |-> $past(state_reg) == rfa_pkg::T_SWAP)
        else $error("other_value set outside exchange");

endmodule

`default_nettype wire
